@@ hw/rtl/sosc_pkg.sv @@
// ---------------------------------------------------------------------------
// sosc_pkg: shared constants for the MIDI-tuned sine oscillator
// Field widths, register and command codes, fixed-point constants of the
// quarter-wave sine polynomial.
// ---------------------------------------------------------------------------
package sosc_pkg;

  // Default sizes of the top level
  localparam int DEF_PHASE_BITS  = 32;
  localparam int DEF_TABLE_BITS  = 10;
  localparam int DEF_SAMPLE_BITS = 16;

  // Field widths
  localparam int CF_W       = 15;   // centre frequency
  localparam int SR_W       = 18;   // sample rate
  localparam int MIDI_W     = 7;    // controller value
  localparam int OFF_W      = 8;    // signed frequency offset
  localparam int FREQ_W     = 16;   // floored oscillator frequency
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 18;

  // Serial multiplier operand width
  localparam int MUL_W = 32;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_FREQ = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE = 1'd1;

  // Input commands
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_MIDI = 1'b1;

  // Reset values
  localparam logic [CF_W-1:0] CENTER_FREQ_RST = 15'd220;
  localparam logic [SR_W-1:0] SAMPLE_RATE_RST = 18'd44100;

  // Fixed point: Q30 one and pi/2 in Q30
  localparam logic [30:0]      Q30_ONE = 31'h4000_0000;
  localparam logic [MUL_W-1:0] PI2_Q30 = 32'd1686629713;

  // Horner divisors of the sine series
  localparam int HORNER_STEPS = 6;

  function automatic logic [7:0] horner_k(input logic [2:0] idx);
    logic [7:0] k;
    case (idx)
      3'd0:    k = 8'd156;
      3'd1:    k = 8'd110;
      3'd2:    k = 8'd72;
      3'd3:    k = 8'd42;
      3'd4:    k = 8'd20;
      3'd5:    k = 8'd6;
      default: k = 8'd1;
    endcase
    return k;
  endfunction

  // Controller value to signed offset in hertz
  function automatic logic signed [OFF_W-1:0] midi_offset(input logic [MIDI_W-1:0] v);
    logic [OFF_W-1:0] twice;
    logic [OFF_W-1:0] off;
    twice = {v, 1'b0};
    if (v < 7'd63) begin
      off = twice - 8'd126;
    end else if (v > 7'd64) begin
      off = twice - 8'd128;
    end else begin
      off = '0;
    end
    return $signed(off);
  endfunction

endpackage

@@ hw/rtl/sine_oscillator_midi_tuned.sv @@
// ---------------------------------------------------------------------------
// sine_oscillator_midi_tuned: phase-accumulator sine oscillator, MIDI bend
// Each tick word advances the phase by freq * 2^PHASE_BITS / sample_rate and
// emits the sine of the new phase as a left/right pair; a MIDI word sets a
// signed frequency offset around the configured centre frequency.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o): command_i selects tick or MIDI
//   update, midi_value_i carries the controller value. A MIDI word is applied
//   as it is taken and yields no output word.
//   Output channel (out_valid_o/out_ready_i): one sample pair per tick.
//   Config channel (cfg_valid_i/cfg_ready_o): index 0 centre frequency (also
//   clears the offset), index 1 sample rate; always ready, write when idle.
//   A tick is computed by the bit-serial multiplier (ten products) and the
//   bit-serial divider (the increment plus six series divisions) before it
//   reaches out_valid_o. One tick is processed at a time; in_ready_o is high
//   while idle, so a new tick is taken only once the last one is through,
//   and MIDI words are taken at one per cycle while idle.
//   A finished sample sits in the output register; the next word is taken
//   while it waits, and a second sample waits in the core until it drains.
//   Reset: phase and offset zero, centre 220 Hz, sample rate 44100 Hz,
//   no output pending.
// ---------------------------------------------------------------------------
module sine_oscillator_midi_tuned
  import sosc_pkg::*;
#(
  parameter int PHASE_BITS  = DEF_PHASE_BITS,
  parameter int TABLE_BITS  = DEF_TABLE_BITS,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input words
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          command_i,
  input  logic [MIDI_W-1:0]             midi_value_i,
  // output words
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [SAMPLE_BITS-1:0] sample_left_o,
  output logic signed [SAMPLE_BITS-1:0] sample_right_o,
  // configuration writes
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [CFG_DATA_W-1:0]         cfg_data_i
);

  localparam int NUM_W  = FREQ_W + PHASE_BITS;
  localparam int QUO_W  = (PHASE_BITS > MUL_W) ? PHASE_BITS : MUL_W;
  localparam int J_W    = TABLE_BITS - 1;
  localparam int MAG_W  = 2 * MUL_W - 29;
  localparam logic [J_W-1:0]         QSIZE = {1'b1, {(TABLE_BITS-2){1'b0}}};
  localparam logic [SAMPLE_BITS-1:0] AMP   = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [2:0]             K_LAST = 3'(HORNER_STEPS - 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_INC,
    S_ANGLE,
    S_MX,
    S_MX2,
    S_MHT,
    S_DHT,
    S_MS,
    S_MAMP,
    S_OUT
  } state_e;

  state_e                   state_q;
  logic                     mul_start_q;
  logic                     div_start_q;
  logic [CF_W-1:0]          center_q;
  logic [SR_W-1:0]          rate_q;
  logic signed [OFF_W-1:0]  offset_q;
  logic [PHASE_BITS-1:0]    phase_q;
  logic [30:0]              x_q;
  logic [MUL_W-1:0]         x2_q;
  logic [30:0]              t_q;
  logic [2:0]               k_q;
  logic                     neg_q;
  logic                     out_valid_q;
  logic [SAMPLE_BITS-1:0]   sample_q;

  logic [MUL_W-1:0]         mul_a;
  logic [MUL_W-1:0]         mul_b;
  logic [2*MUL_W-1:0]       mul_prod;
  logic                     mul_done;
  logic [NUM_W-1:0]         div_num;
  logic [SR_W-1:0]          div_den;
  logic [QUO_W-1:0]         div_quo;
  logic                     div_done;

  logic signed [FREQ_W:0]   freq_sum;
  logic [FREQ_W-1:0]        freq;
  logic [PHASE_BITS-1:0]    inc;
  logic [TABLE_BITS-1:0]    tbl_idx;
  logic [J_W-1:0]           j_raw;
  logic [J_W-1:0]           j;
  logic [MAG_W:0]           mag_rnd;
  logic [MAG_W-1:0]         mag_full;
  logic [SAMPLE_BITS-1:0]   mag;
  logic [SAMPLE_BITS-1:0]   sample;
  logic                     in_take;
  logic                     midi_take;
  logic                     out_free;
  logic                     out_load;

  // Oscillator frequency, floored at zero
  assign freq_sum = $signed({2'b00, center_q}) + (FREQ_W+1)'(offset_q);
  assign freq     = freq_sum[FREQ_W] ? '0 : freq_sum[FREQ_W-1:0];
  assign inc      = (rate_q == '0) ? '0 : div_quo[PHASE_BITS-1:0];

  // Quarter-wave reduction of the table index
  assign tbl_idx = phase_q[PHASE_BITS-1 -: TABLE_BITS];
  assign j_raw   = {1'b0, tbl_idx[TABLE_BITS-3:0]};
  assign j       = tbl_idx[TABLE_BITS-2] ? (QSIZE - j_raw) : j_raw;

  // Round, saturate and sign the magnitude
  assign mag_rnd  = {1'b0, mul_prod[2*MUL_W-1:29]} + 1'b1;
  assign mag_full = mag_rnd[MAG_W:1];
  assign mag      = (mag_full > MAG_W'(AMP)) ? AMP : mag_full[SAMPLE_BITS-1:0];
  assign sample   = neg_q ? (SAMPLE_BITS'(0) - mag) : mag;

  // Operand selection for the shared multiplier
  always_comb begin
    case (state_q)
      S_MX: begin
        mul_a = PI2_Q30;
        mul_b = MUL_W'(j);
      end
      S_MX2: begin
        mul_a = MUL_W'(x_q);
        mul_b = MUL_W'(x_q);
      end
      S_MHT: begin
        mul_a = x2_q;
        mul_b = MUL_W'(t_q);
      end
      S_MS: begin
        mul_a = MUL_W'(x_q);
        mul_b = MUL_W'(t_q);
      end
      S_MAMP: begin
        mul_a = MUL_W'(mul_prod[60:30]);
        mul_b = MUL_W'(AMP);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Operand selection for the shared divider
  always_comb begin
    if (state_q == S_INC) begin
      div_num = {freq, {PHASE_BITS{1'b0}}};
      div_den = rate_q;
    end else begin
      div_num = NUM_W'(mul_prod[61:30]);
      div_den = SR_W'(horner_k(k_q));
    end
  end

  sosc_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start_q),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .prod_o  (mul_prod),
    .done_o  (mul_done)
  );

  sosc_div #(
    .NUM_W (NUM_W),
    .DEN_W (SR_W),
    .QUO_W (QUO_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start_q),
    .num_i   (div_num),
    .den_i   (div_den),
    .quo_o   (div_quo),
    .done_o  (div_done)
  );

  assign in_take   = in_valid_i && (state_q == S_IDLE);
  assign midi_take = in_take && (command_i == CMD_MIDI);
  assign out_free  = !out_valid_q || out_ready_i;
  assign out_load  = (state_q == S_OUT) && out_free;

  // Sequencer, configuration and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mul_start_q <= 1'b0;
      div_start_q <= 1'b0;
      center_q    <= CENTER_FREQ_RST;
      rate_q      <= SAMPLE_RATE_RST;
      offset_q    <= '0;
      phase_q     <= '0;
      x_q         <= '0;
      x2_q        <= '0;
      t_q         <= '0;
      k_q         <= '0;
      neg_q       <= 1'b0;
      out_valid_q <= 1'b0;
      sample_q    <= '0;
    end else begin
      mul_start_q <= 1'b0;
      div_start_q <= 1'b0;

      // load a finished sample, or drop the output word once taken
      if (out_load) begin
        out_valid_q <= 1'b1;
        sample_q    <= sample;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      // configuration writes
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          REG_CENTER_FREQ: center_q <= cfg_data_i[CF_W-1:0];
          REG_SAMPLE_RATE: rate_q   <= cfg_data_i;
          default: ;
        endcase
      end

      // set the offset from a controller word, clear it on a centre write
      if (midi_take) begin
        offset_q <= midi_offset(midi_value_i);
      end else if (cfg_valid_i && (cfg_index_i == REG_CENTER_FREQ)) begin
        offset_q <= '0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_take && (command_i == CMD_TICK)) begin
            div_start_q <= 1'b1;
            state_q     <= S_INC;
          end
        end
        S_INC: begin
          if (div_done) begin
            phase_q <= phase_q + inc;
            state_q <= S_ANGLE;
          end
        end
        S_ANGLE: begin
          neg_q       <= tbl_idx[TABLE_BITS-1];
          mul_start_q <= 1'b1;
          state_q     <= S_MX;
        end
        S_MX: begin
          if (mul_done) begin
            x_q         <= mul_prod[TABLE_BITS-2 +: 31];
            mul_start_q <= 1'b1;
            state_q     <= S_MX2;
          end
        end
        S_MX2: begin
          if (mul_done) begin
            x2_q        <= mul_prod[61:30];
            t_q         <= Q30_ONE;
            k_q         <= '0;
            mul_start_q <= 1'b1;
            state_q     <= S_MHT;
          end
        end
        S_MHT: begin
          if (mul_done) begin
            div_start_q <= 1'b1;
            state_q     <= S_DHT;
          end
        end
        S_DHT: begin
          if (div_done) begin
            t_q         <= Q30_ONE - div_quo[30:0];
            mul_start_q <= 1'b1;
            if (k_q == K_LAST) begin
              state_q <= S_MS;
            end else begin
              k_q     <= k_q + 1'b1;
              state_q <= S_MHT;
            end
          end
        end
        S_MS: begin
          if (mul_done) begin
            mul_start_q <= 1'b1;
            state_q     <= S_MAMP;
          end
        end
        S_MAMP: begin
          if (mul_done) begin
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          // hold the sample until the output register is free
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o     = (state_q == S_IDLE);
  assign cfg_ready_o    = 1'b1;
  assign out_valid_o    = out_valid_q;
  assign sample_left_o  = $signed(sample_q);
  assign sample_right_o = $signed(sample_q);

endmodule

@@ hw/rtl/sosc_mul.sv @@
// ---------------------------------------------------------------------------
// sosc_mul: bit-serial shift-add multiplier
// Unsigned MUL_W x MUL_W product, one multiplier bit per cycle, LSB first.
// The product holds until the next start.
// ---------------------------------------------------------------------------
module sosc_mul
  import sosc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [MUL_W-1:0]     a_i,
  input  logic [MUL_W-1:0]     b_i,
  output logic [2*MUL_W-1:0]   prod_o,
  output logic                 done_o
);

  localparam int CNT_W = $clog2(MUL_W + 1);

  logic [CNT_W-1:0] cnt_q;
  logic             done_q;
  logic [MUL_W-1:0] a_q;
  logic [MUL_W-1:0] hi_q;
  logic [MUL_W-1:0] lo_q;
  logic [MUL_W:0]   sum;

  // Add the multiplicand when the current multiplier bit is set
  assign sum = {1'b0, hi_q} + (lo_q[0] ? {1'b0, a_q} : '0);

  // Step counter and completion pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= CNT_W'(MUL_W);
      end else if (cnt_q != '0) begin
        cnt_q  <= cnt_q - 1'b1;
        done_q <= (cnt_q == CNT_W'(1));
      end
    end
  end

  // Shift the partial product right by one bit a cycle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q  <= a_i;
      hi_q <= '0;
      lo_q <= b_i;
    end else if (cnt_q != '0) begin
      hi_q <= sum[MUL_W:1];
      lo_q <= {sum[0], lo_q[MUL_W-1:1]};
    end
  end

  assign prod_o = {hi_q, lo_q};
  assign done_o = done_q;

endmodule

@@ hw/rtl/sosc_div.sv @@
// ---------------------------------------------------------------------------
// sosc_div: bit-serial restoring divider
// One quotient bit per cycle, dividend bits taken MSB first. Quotient keeps
// its low QUO_W bits. The quotient holds until the next start.
// ---------------------------------------------------------------------------
module sosc_div
  import sosc_pkg::*;
#(
  parameter int NUM_W = 48,
  parameter int DEN_W = 18,
  parameter int QUO_W = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [QUO_W-1:0] quo_o,
  output logic             done_o
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0] cnt_q;
  logic             done_q;
  logic [NUM_W-1:0] num_q;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W-1:0] rem_q;
  logic [QUO_W-1:0] quo_q;
  logic [DEN_W:0]   rem2;
  logic [DEN_W:0]   diff;
  logic             ge;

  // Bring down the next dividend bit and trial-subtract
  assign rem2 = {rem_q, num_q[NUM_W-1]};
  assign diff = rem2 - {1'b0, den_q};
  assign ge   = (rem2 >= {1'b0, den_q});

  // Step counter and completion pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= CNT_W'(NUM_W);
      end else if (cnt_q != '0) begin
        cnt_q  <= cnt_q - 1'b1;
        done_q <= (cnt_q == CNT_W'(1));
      end
    end
  end

  // Advance remainder and quotient by one digit
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (cnt_q != '0) begin
      num_q <= {num_q[NUM_W-2:0], 1'b0};
      rem_q <= ge ? diff[DEN_W-1:0] : rem2[DEN_W-1:0];
      quo_q <= {quo_q[QUO_W-2:0], ge};
    end
  end

  assign quo_o  = quo_q;
  assign done_o = done_q;

endmodule

@@ verif/sine_oscillator_midi_tuned_tb.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// sine_oscillator_midi_tuned_tb: self-checking bench for the MIDI-tuned sine
// oscillator
// A table of directed words and register writes covers the quarter-turn
// points, the flooring of negative frequencies, a zero or out-of-range sample
// rate and the controller extremes. Random phases follow, each with its own
// centre frequency and sample rate. Every tick word is predicted by a
// behavioural copy of the oscillator and each sample pair is checked in order.
// ---------------------------------------------------------------------------
module sine_oscillator_midi_tuned_tb;
  import sosc_pkg::*;

  localparam int SW             = DEF_SAMPLE_BITS;
  localparam int PW             = DEF_PHASE_BITS;
  localparam int TW             = DEF_TABLE_BITS;
  localparam longint unsigned AMP = (64'd1 << (SW - 1)) - 1;
  localparam longint unsigned ONE_Q30 = 64'd1 << 30;
  localparam int SETTLE_CYCLES  = 720;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASE_WORDS    = 230;
  localparam int N_PHASES       = 6;
  localparam int N_ROWS         = 33;

  // Divisors of the nested sine series, innermost first
  localparam int unsigned SERIES_DIV [6] = '{156, 110, 72, 42, 20, 6};

  typedef enum logic [0:0] {ROW_CFG, ROW_WORD} row_kind_e;

  typedef struct packed {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_data;
    logic                  cmd;
    logic [MIDI_W-1:0]     midi;
    logic                  has_want;
    logic [SW-1:0]         want;
  } stim_row_t;

  // Directed words; a fixed sample is given only where it is obvious
  localparam stim_row_t DIRECTED [N_ROWS] = '{
    '{ROW_CFG,  REG_SAMPLE_RATE, 18'd0,      CMD_TICK, 7'd0,   1'b0, 16'd0},
    '{ROW_WORD, REG_CENTER_FREQ, 18'd0,      CMD_TICK, 7'd127, 1'b1, 16'd0},
    '{ROW_WORD, REG_CENTER_FREQ, 18'd0,      CMD_MIDI, 7'd0,   1'b0, 16'd0},
    '{ROW_WORD, REG_CENTER_FREQ, 18'd0,      CMD_MIDI, 7'd127, 1'b0, 16'd0},
    '{ROW_CFG,  REG_CENTER_FREQ, 18'd1,      CMD_TICK, 7'd0,   1'b0, 16'd0},
    '{ROW_CFG,  REG_SAMPLE_RATE, 18'd4,      CMD_TICK, 7'd0,   1'b0, 16'd0},
    '{ROW_WORD, REG_CENTER_FREQ, 18'd0,      CMD_TICK, 7'd85,  1'b1, 16'h7FFF},
    '{ROW_WORD, REG_CENTER_FREQ, 18'd0,      CMD_TICK, 7'd42,  1'b1, 16'd0},
    '{ROW_WORD, REG_CENTER_FREQ, 18'd0,      CMD_TICK, 7'd0,   1'b1, 16'h8001},
    '{ROW_WORD, REG_CENTER_FREQ, 18'd0,      CMD_TICK, 7'd0,   1'b1, 16'd0},
    '{ROW_WORD, REG_CENTER_FREQ, 18'd0,      CMD_MIDI, 7'd0,   1'b0, 16'd0},
    '{ROW_WORD, REG_CENTER_FREQ, 18'd0,      CMD_TICK, 7'd0,   1'b1, 16'd0},
    '{ROW_WORD, REG_CENTER_FREQ, 18'd0,      CMD_MIDI, 7'd64,  1'b0, 16'd0},
    '{ROW_WORD, REG_CENTER_FREQ, 18'd0,      CMD_TICK, 7'd0,   1'b1, 16'h7FFF},
    '{ROW_WORD, REG_CENTER_FREQ, 18'd0,      CMD_MIDI, 7'd63,  1'b0, 16'd0},
    '{ROW_WORD, REG_CENTER_FREQ, 18'd0,      CMD_TICK, 7'd0,   1'b1, 16'd0},
    '{ROW_WORD, REG_CENTER_FREQ, 18'd0,      CMD_MIDI, 7'd127, 1'b0, 16'd0},
    '{ROW_WORD, REG_CENTER_FREQ, 18'd0,      CMD_TICK, 7'd0,   1'b0, 16'd0},
    '{ROW_CFG,  REG_CENTER_FREQ, 18'd32767,  CMD_TICK, 7'd0,   1'b0, 16'd0},
    '{ROW_CFG,  REG_SAMPLE_RATE, 18'h3FFFF,  CMD_TICK, 7'd0,   1'b0, 16'd0},
    '{ROW_WORD, REG_CENTER_FREQ, 18'd0,      CMD_TICK, 7'd0,   1'b0, 16'd0},
    '{ROW_WORD, REG_CENTER_FREQ, 18'd0,      CMD_MIDI, 7'd127, 1'b0, 16'd0},
    '{ROW_WORD, REG_CENTER_FREQ, 18'd0,      CMD_TICK, 7'd0,   1'b0, 16'd0},
    '{ROW_WORD, REG_CENTER_FREQ, 18'd0,      CMD_MIDI, 7'd0,   1'b0, 16'd0},
    '{ROW_WORD, REG_CENTER_FREQ, 18'd0,      CMD_TICK, 7'd0,   1'b0, 16'd0},
    '{ROW_CFG,  REG_SAMPLE_RATE, 18'd1,      CMD_TICK, 7'd0,   1'b0, 16'd0},
    '{ROW_WORD, REG_CENTER_FREQ, 18'd0,      CMD_TICK, 7'd0,   1'b0, 16'd0},
    '{ROW_CFG,  REG_CENTER_FREQ, 18'd0,      CMD_TICK, 7'd0,   1'b0, 16'd0},
    '{ROW_CFG,  REG_SAMPLE_RATE, 18'd192000, CMD_TICK, 7'd0,   1'b0, 16'd0},
    '{ROW_WORD, REG_CENTER_FREQ, 18'd0,      CMD_MIDI, 7'd100, 1'b0, 16'd0},
    '{ROW_WORD, REG_CENTER_FREQ, 18'd0,      CMD_TICK, 7'd0,   1'b0, 16'd0},
    '{ROW_WORD, REG_CENTER_FREQ, 18'd0,      CMD_MIDI, 7'd1,   1'b0, 16'd0},
    '{ROW_WORD, REG_CENTER_FREQ, 18'd0,      CMD_TICK, 7'd0,   1'b0, 16'd0}
  };

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  logic                  command   = CMD_TICK;
  logic [MIDI_W-1:0]     midi_value = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic signed [SW-1:0]  sample_left;
  logic signed [SW-1:0]  sample_right;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_CENTER_FREQ;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // Oscillator copy: registers and state
  logic [CF_W-1:0]       osc_center = CENTER_FREQ_RST;
  logic [SR_W-1:0]       osc_rate   = SAMPLE_RATE_RST;
  logic [PW-1:0]         osc_phase  = '0;
  logic signed [7:0]     osc_bend   = '0;

  logic signed [SW-1:0]  pending_samples [$];
  int                    mismatches = 0;
  int                    quiet_cycles = 0;
  int                    stall_left = 0;
  bit                    idle_on = 1'b1;

  always #2 clk = ~clk;

  sine_oscillator_midi_tuned DUT (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .command_i      (command),
    .midi_value_i   (midi_value),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .sample_left_o  (sample_left),
    .sample_right_o (sample_right),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  // Controller value to frequency bend in hertz
  function automatic logic signed [7:0] bend_of(input logic [MIDI_W-1:0] v);
    int b;
    if (v < 63) begin
      b = -2 * (63 - int'(v));
    end else if (v > 64) begin
      b = 2 * (int'(v) - 64);
    end else begin
      b = 0;
    end
    return 8'(b);
  endfunction

  // Phase advance per tick: floor(freq * 2^32 / rate), wrapped
  function automatic logic [PW-1:0] phase_step();
    int              f;
    longint unsigned num;
    f = int'(osc_center) + int'(osc_bend);
    if (f < 0) f = 0;
    if (osc_rate == 0) return '0;
    num = longint'(f) << PW;
    return PW'(num / 64'(osc_rate));
  endfunction

  // Magnitude of the sine over the first quarter turn, index 0..2^(TW-2)
  function automatic longint unsigned quarter_mag(input int j);
    longint unsigned x, x2, t, s, m;
    x  = (64'(PI2_Q30) * 64'(j)) >> (TW - 2);
    x2 = (x * x) >> 30;
    t  = ONE_Q30;
    for (int k = 0; k < 6; k++) begin
      t = ONE_Q30 - ((x2 * t) >> 30) / 64'(SERIES_DIV[k]);
    end
    s = (x * t) >> 30;
    m = (s * AMP + (64'd1 << 29)) >> 30;
    return (m > AMP) ? AMP : m;
  endfunction

  // Fold the phase onto the quarter wave and restore the sign
  function automatic logic signed [SW-1:0] sine_sample(input logic [PW-1:0] ph);
    logic [TW-1:0]   idx;
    logic [1:0]      quad;
    int              j;
    longint unsigned m;
    idx  = ph[PW-1 -: TW];
    quad = idx[TW-1 -: 2];
    j    = int'(idx[TW-3:0]);
    if (quad[0]) j = (1 << (TW - 2)) - j;
    m = quarter_mag(j);
    return quad[1] ? SW'(64'd0 - m) : SW'(m);
  endfunction

  task automatic note_mismatch(input string msg);
    $display("%0t: mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  // Present one word and hold it until taken; predict on acceptance
  task automatic send_word(input logic cmd, input logic [MIDI_W-1:0] midi,
                           input logic has_want, input logic [SW-1:0] want);
    logic signed [SW-1:0] predicted;
    @(negedge clk);
    in_valid   <= 1'b1;
    command    <= cmd;
    midi_value <= midi;
    do @(posedge clk); while (!in_ready);
    if (cmd == CMD_MIDI) begin
      osc_bend = bend_of(midi);
    end else begin
      osc_phase = osc_phase + phase_step();
      predicted = sine_sample(osc_phase);
      pending_samples.push_back(has_want ? $signed(want) : predicted);
    end
  endtask

  // Drop valid for a random burst now and then
  task automatic maybe_gap();
    if (idle_on && $urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 19)) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
    end
  endtask

  // Drain all samples, then wait for the settle time
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_CENTER_FREQ) begin
      osc_center = data[CF_W-1:0];
      osc_bend   = '0;
    end else begin
      osc_rate = data[SR_W-1:0];
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Output side: stall in random bursts while a sample is offered
  always @(negedge clk) begin
    if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_on && out_valid && $urandom_range(0, 2) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 18);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Check each sample pair against the oldest prediction
  always @(posedge clk) begin
    logic signed [SW-1:0] want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_samples.size() == 0) begin
        note_mismatch($sformatf("sample %0d with nothing pending", sample_left));
      end else begin
        want = pending_samples.pop_front();
        if (sample_left !== want)
          note_mismatch($sformatf("left %0d, expected %0d", sample_left, want));
        if (sample_right !== want)
          note_mismatch($sformatf("right %0d, expected %0d", sample_right, want));
      end
    end
  end

  // Watchdog: end the run if no word moves for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired at %0t", $realtime);
      $display("sine_oscillator_midi_tuned_tb failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [CFG_DATA_W-1:0] cf, sr;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // Directed table
    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].kind == ROW_CFG) begin
        wait_idle();
        write_reg(DIRECTED[i].reg_idx, DIRECTED[i].reg_data);
      end else begin
        maybe_gap();
        send_word(DIRECTED[i].cmd, DIRECTED[i].midi, DIRECTED[i].has_want,
                  DIRECTED[i].want);
      end
    end

    // Random phases, each with its own tuning
    for (int p = 0; p < N_PHASES; p++) begin
      case (p)
        0: begin
          cf = CFG_DATA_W'($urandom_range(0, 32767));
          sr = CFG_DATA_W'($urandom_range(1, 192000));
        end
        1: begin
          cf = '0;
          sr = CFG_DATA_W'(1);
        end
        2: begin
          cf = CFG_DATA_W'(32767);
          sr = '1;
        end
        3: begin
          cf = CFG_DATA_W'(CENTER_FREQ_RST);
          sr = CFG_DATA_W'(SAMPLE_RATE_RST);
        end
        4: begin
          cf = CFG_DATA_W'($urandom_range(0, (1 << CFG_DATA_W) - 1));
          sr = CFG_DATA_W'($urandom_range(0, (1 << CFG_DATA_W) - 1));
        end
        default: begin
          cf = CFG_DATA_W'($urandom_range(0, 2000));
          sr = CFG_DATA_W'($urandom_range(8000, 192000));
        end
      endcase
      // No idling in the quiet stretch and in the closing phase
      idle_on = (p != 3) && (p != N_PHASES - 1);
      wait_idle();
      if ($urandom_range(0, 1) == 0) begin
        write_reg(REG_CENTER_FREQ, cf);
        write_reg(REG_SAMPLE_RATE, sr);
      end else begin
        write_reg(REG_SAMPLE_RATE, sr);
        write_reg(REG_CENTER_FREQ, cf);
      end
      repeat (PHASE_WORDS) begin
        maybe_gap();
        send_word(($urandom_range(0, 1) == 0) ? CMD_TICK : CMD_MIDI,
                  MIDI_W'($urandom_range(0, 127)), 1'b0, '0);
      end
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("sine_oscillator_midi_tuned_tb passed");
    end else begin
      $display("sine_oscillator_midi_tuned_tb failed");
    end
    $finish;
  end

endmodule

@@ sine_oscillator_midi_tuned.f @@
hw/rtl/sosc_pkg.sv
hw/rtl/sosc_mul.sv
hw/rtl/sosc_div.sv
hw/rtl/sine_oscillator_midi_tuned.sv
verif/sine_oscillator_midi_tuned_tb.sv
